// ===== design/isfl_pkg.sv =====
// Shared types and constants of the indexed slot free list.
package isfl_pkg;

    // Fixed port field widths
    localparam int REQ_W    = 3;
    localparam int IDX_W    = 10;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;

    // Request codes; codes 5 to 7 are ignored
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_ERASE  = 3'd1,
        REQ_READ   = 3'd2,
        REQ_QUERY  = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_LIVE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

// ===== design/isfl_store.sv =====
// Slot data memory and slot metadata memory (live bit plus free link).
module isfl_store #(
    parameter int DEPTH = 1024,
    parameter int SW    = 32,
    parameter int IW    = 10,
    parameter int MW    = 12
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_meta_raddr,
    input  logic [IW-1:0] i_data_raddr,
    output logic [MW-1:0] o_meta_rdata,
    output logic [SW-1:0] o_data_rdata,
    input  logic          i_meta_we,
    input  logic [IW-1:0] i_meta_waddr,
    input  logic [MW-1:0] i_meta_wdata,
    input  logic          i_data_we,
    input  logic [IW-1:0] i_data_waddr,
    input  logic [SW-1:0] i_data_wdata
);

    logic [MW-1:0] r_meta_mem [DEPTH];
    logic [SW-1:0] r_data_mem [DEPTH];
    logic [MW-1:0] r_meta_rdata;
    logic [SW-1:0] r_data_rdata;

    always_ff @(posedge i_clk) begin
        if (i_meta_we) begin
            r_meta_mem[i_meta_waddr] <= i_meta_wdata;
        end
        if (i_rd_en) begin
            r_meta_rdata <= r_meta_mem[i_meta_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data_we) begin
            r_data_mem[i_data_waddr] <= i_data_wdata;
        end
        if (i_rd_en) begin
            r_data_rdata <= r_data_mem[i_data_raddr];
        end
    end

    assign o_meta_rdata = r_meta_rdata;
    assign o_data_rdata = r_data_rdata;

endmodule

// ===== design/indexed_slot_free_list.sv =====
// Top level of the indexed slot free list: control, counters and result register.
//
//  channel  direction  handshake                  payload
//  request  in         i_in_valid / o_in_ready    i_req_type, i_slot_index, i_entry_data
//  result   out        o_out_valid / i_out_ready  o_alloc_index, o_read_data,
//                                                 o_slot_is_free, o_live_count,
//                                                 o_free_count, o_status
//
// Each transaction is accepted and then resolved: the accept edge issues the memory reads
// (free head link or addressed slot), and the resolve state then resolves, writes
// back and loads the result register. The registered memory read sets this.
// A pending result does not block the accept; a second result waits in the
// resolve cycle until the result register drains.
// Reset (synchronous, i_rst_n low) and the clear request empty the store
// at once: no clearing pass is needed, since only slots below the
// high-water mark are ever looked up and each of them was written.
module indexed_slot_free_list #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [isfl_pkg::REQ_W-1:0]     i_req_type,
    input  logic [isfl_pkg::IDX_W-1:0]     i_slot_index,
    input  logic [isfl_pkg::DATA_W-1:0]    i_entry_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [isfl_pkg::IDX_W-1:0]     o_alloc_index,
    output logic [isfl_pkg::DATA_W-1:0]    o_read_data,
    output logic                           o_slot_is_free,
    output logic [isfl_pkg::CNT_W-1:0]     o_live_count,
    output logic [isfl_pkg::CNT_W-1:0]     o_free_count,
    output logic [isfl_pkg::STATUS_W-1:0]  o_status
);

    import isfl_pkg::*;

    localparam int IW = $clog2(DEPTH);          // slot address
    localparam int CW = $clog2(DEPTH + 1);      // counts and links (null = DEPTH)
    localparam int MW = CW + 1;                 // {live, link}
    localparam int SW = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] NULL_LINK = CW'(DEPTH);

    // control state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_free_head, n_free_head;
    logic [CW-1:0]    r_high_water, n_high_water;
    logic [CW-1:0]    r_free_total, n_free_total;
    logic             r_out_valid;

    // captured request
    logic [REQ_W-1:0] r_req;
    logic [IDX_W-1:0] r_idx;
    logic [SW-1:0]    r_data;

    // result register
    logic [IDX_W-1:0]    r_alloc, n_alloc;
    logic [DATA_W-1:0]   r_rdata, n_rdata;
    logic                r_is_free, n_is_free;
    logic [STATUS_W-1:0] r_status;
    t_status             n_status;
    logic [CNT_W-1:0]    r_live_cnt, r_free_cnt;

    // memory interface
    logic          in_acc, commit;
    logic [IW-1:0] meta_raddr;
    logic [MW-1:0] meta_rdata;
    logic [SW-1:0] data_rdata;
    logic          meta_we, data_we;
    logic [IW-1:0] meta_waddr, data_waddr;
    logic [MW-1:0] meta_wdata;
    logic          in_range, slot_live;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // an insert looks at the free head's link, the rest at the addressed slot
    assign meta_raddr = (i_req_type == REQ_INSERT) ? IW'(r_free_head) : IW'(i_slot_index);

    isfl_store #(
        .DEPTH (DEPTH),
        .SW    (SW),
        .IW    (IW),
        .MW    (MW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_en      (in_acc),
        .i_meta_raddr (meta_raddr),
        .i_data_raddr (IW'(i_slot_index)),
        .o_meta_rdata (meta_rdata),
        .o_data_rdata (data_rdata),
        .i_meta_we    (meta_we),
        .i_meta_waddr (meta_waddr),
        .i_meta_wdata (meta_wdata),
        .i_data_we    (data_we),
        .i_data_waddr (data_waddr),
        .i_data_wdata (r_data)
    );

    assign in_range  = XW'(r_idx) < XW'(r_high_water);
    assign slot_live = meta_rdata[MW-1];

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_high_water = r_high_water;
        n_free_total = r_free_total;
        n_alloc      = '0;
        n_rdata      = '0;
        n_is_free    = 1'b0;
        n_status     = ST_OK;
        meta_we      = 1'b0;
        data_we      = 1'b0;
        meta_waddr   = IW'(r_idx);
        data_waddr   = IW'(r_idx);
        meta_wdata   = {1'b0, r_free_head};

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                    priority if (r_req == REQ_INSERT) begin
                        if (r_free_total != '0 && r_free_head < NULL_LINK) begin
                            // pop the most recently freed slot
                            meta_we      = 1'b1;
                            data_we      = 1'b1;
                            meta_waddr   = IW'(r_free_head);
                            data_waddr   = IW'(r_free_head);
                            meta_wdata   = {1'b1, meta_rdata[CW-1:0]};
                            n_free_head  = meta_rdata[CW-1:0];
                            n_free_total = r_free_total - CW'(1);
                            n_alloc      = IDX_W'(r_free_head);
                        end else if (r_high_water < NULL_LINK) begin
                            // fresh slot at the high-water mark
                            meta_we      = 1'b1;
                            data_we      = 1'b1;
                            meta_waddr   = IW'(r_high_water);
                            data_waddr   = IW'(r_high_water);
                            meta_wdata   = {1'b1, NULL_LINK};
                            n_high_water = r_high_water + CW'(1);
                            n_alloc      = IDX_W'(r_high_water);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else if (r_req == REQ_ERASE || r_req == REQ_READ
                                 || r_req == REQ_QUERY) begin
                        if (!in_range) begin
                            n_status = ST_RANGE;
                        end else if (r_req == REQ_QUERY) begin
                            n_is_free = !slot_live;
                        end else if (!slot_live) begin
                            n_status = ST_NOT_LIVE;
                        end else if (r_req == REQ_READ) begin
                            n_rdata = DATA_W'(data_rdata);
                        end else begin
                            // push onto the free list
                            meta_we      = 1'b1;
                            meta_wdata   = {1'b0, r_free_head};
                            n_free_head  = CW'(r_idx);
                            n_free_total = r_free_total + CW'(1);
                        end
                    end else if (r_req == REQ_CLEAR) begin
                        n_free_head  = NULL_LINK;
                        n_high_water = '0;
                        n_free_total = '0;
                    end else begin
                        n_status = ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= NULL_LINK;
            r_high_water <= '0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_high_water <= n_high_water;
            r_free_total <= n_free_total;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= i_req_type;
            r_idx  <= i_slot_index;
            r_data <= SW'(i_entry_data);
        end
        if (commit) begin
            r_alloc    <= n_alloc;
            r_rdata    <= n_rdata;
            r_is_free  <= n_is_free;
            r_status   <= n_status;
            r_live_cnt <= CNT_W'(n_high_water - n_free_total);
            r_free_cnt <= CNT_W'(n_free_total);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_alloc_index  = r_alloc;
    assign o_read_data    = r_rdata;
    assign o_slot_is_free = r_is_free;
    assign o_live_count   = r_live_cnt;
    assign o_free_count   = r_free_cnt;
    assign o_status       = r_status;

    // free slots are always a subset of used slots
    a_free_le_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= r_high_water)
        else $error("free count exceeds high-water mark");

    // empty free list and null head go together
    a_head_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_total == '0) == (r_free_head == NULL_LINK))
        else $error("free head and free count disagree");

    // an accepted transaction enters the resolve state in the following cycle
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accept did not move to resolve");

    // a resolve with the result register blocked must not drop its result
    a_exec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && !i_out_ready) |=> (r_state == S_EXEC))
        else $error("result lost while output stalled");

endmodule
